[rtl/scl_pkg.sv]
// ----------------------------------------------------------------------------
// scl_pkg
// Shared types, character codes and helpers of the serial command line parser.
// ----------------------------------------------------------------------------
package scl_pkg;

  localparam int SCL_LINE_DEPTH = 64;

  // result kinds
  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_MOVE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // error codes
  localparam logic ERR_OVERFLOW = 1'b0;
  localparam logic ERR_FORMAT   = 1'b1;

  // character codes
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_COLON = 8'd58;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_TAB   = 8'd9;

  // operations of the shared accumulate unit
  typedef enum logic [1:0] {
    OP_PASS = 2'd0,
    OP_MAC  = 2'd1,
    OP_NEG  = 2'd2
  } scl_op_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         tx_byte;
    logic signed [31:0] pan;
    logic signed [31:0] tilt;
    logic               error_code;
    logic               last;
  } scl_result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

[rtl/scl_ifs.sv]
// ----------------------------------------------------------------------------
// scl channel interfaces
// Valid/ready channels for received bytes and for result requests.
// ----------------------------------------------------------------------------
interface scl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface scl_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [7:0]         tx_byte;
  logic signed [31:0] pan;
  logic signed [31:0] tilt;
  logic               error_code;
  logic               last;

  modport source (output valid, output kind, output tx_byte, output pan, output tilt,
                  output error_code, output last, input ready);
  modport sink (input valid, input kind, input tx_byte, input pan, input tilt,
                input error_code, input last, output ready);
endinterface

[rtl/serial_command_line_parser_unit.sv]
// The echo of a byte is pushed from the echo state once the output register is free.
// A line end on a non-empty line walks the line character by character; the move or
// error request is then pushed from the report state once the output is free.
// New bytes are taken only in the idle state, after all requests of the last byte.
// Reset clears the control state and the line length; the line store is not cleared.
// ----------------------------------------------------------------------------
// serial_command_line_parser_unit
// Line editor with echo and a two-integer "pan:tilt" command parser.
// ----------------------------------------------------------------------------
module serial_command_line_parser_unit #(
  parameter int LINE_DEPTH = scl_pkg::SCL_LINE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  scl_in_if.sink     in_ch,
  scl_out_if.source  out_ch
);
  import scl_pkg::*;

  localparam int ADDR_W = $clog2(LINE_DEPTH);

  logic              in_ready;
  logic              out_free;
  logic              push;
  scl_result_t       res;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_rdata;
  scl_op_t           unit_op;
  logic [31:0]       unit_acc;
  logic [3:0]        unit_digit;
  logic [31:0]       unit_res;

  logic              out_valid_r;
  scl_result_t       out_res_r;

  scl_ctrl #(
    .LINE_DEPTH (LINE_DEPTH),
    .ADDR_W     (ADDR_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_rx_byte (in_ch.rx_byte),
    .in_ready   (in_ready),
    .out_free   (out_free),
    .push       (push),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .unit_op    (unit_op),
    .unit_acc   (unit_acc),
    .unit_digit (unit_digit),
    .unit_res   (unit_res)
  );

  scl_line_mem #(
    .LINE_DEPTH (LINE_DEPTH),
    .ADDR_W     (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  scl_acc_unit u_acc (
    .op    (unit_op),
    .acc   (unit_acc),
    .digit (unit_digit),
    .res   (unit_res)
  );

  assign out_free = !out_valid_r || out_ch.ready;

  // output register: hold a request until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_res_r <= res;
    end
  end

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_res_r.kind;
  assign out_ch.tx_byte    = out_res_r.tx_byte;
  assign out_ch.pan        = out_res_r.pan;
  assign out_ch.tilt       = out_res_r.tilt;
  assign out_ch.error_code = out_res_r.error_code;
  assign out_ch.last       = out_res_r.last;

endmodule

[rtl/scl_line_mem.sv]
// ----------------------------------------------------------------------------
// scl_line_mem
// Line store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module scl_line_mem #(
  parameter int LINE_DEPTH = 64,
  parameter int ADDR_W     = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [LINE_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/scl_acc_unit.sv]
// ----------------------------------------------------------------------------
// scl_acc_unit
// Shared arithmetic unit: decimal multiply-accumulate, negate or pass.
// ----------------------------------------------------------------------------
module scl_acc_unit (
  input  scl_pkg::scl_op_t op,
  input  logic [31:0]      acc,
  input  logic [3:0]       digit,
  output logic [31:0]      res
);
  import scl_pkg::*;

  logic [35:0] prod;

  always_comb begin
    prod = {4'b0, acc} * 36'd10;
    unique case (op)
      OP_MAC:  res = prod[31:0] + {28'b0, digit};
      OP_NEG:  res = 32'd0 - acc;
      OP_PASS: res = acc;
      default: res = acc;
    endcase
  end

endmodule

[rtl/scl_ctrl.sv]
// ----------------------------------------------------------------------------
// scl_ctrl
// Sequencer: echo, line editing and the character walk of the line parser.
// ----------------------------------------------------------------------------
module scl_ctrl #(
  parameter int LINE_DEPTH = 64,
  parameter int ADDR_W     = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [7:0]           in_rx_byte,
  output logic                 in_ready,
  input  logic                 out_free,
  output logic                 push,
  output scl_pkg::scl_result_t res,
  output logic                 mem_we,
  output logic [ADDR_W-1:0]    mem_waddr,
  output logic [7:0]           mem_wdata,
  output logic [ADDR_W-1:0]    mem_raddr,
  input  logic [7:0]           mem_rdata,
  output scl_pkg::scl_op_t     unit_op,
  output logic [31:0]          unit_acc,
  output logic [3:0]           unit_digit,
  input  logic [31:0]          unit_res
);
  import scl_pkg::*;

  localparam logic [ADDR_W-1:0] LEN_MAX = ADDR_W'(LINE_DEPTH - 1);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_ECHO   = 11'b000_0000_0010,
    S_SPACE  = 11'b000_0000_0100,
    S_BKSP   = 11'b000_0000_1000,
    S_OVF    = 11'b000_0001_0000,
    S_SKIP   = 11'b000_0010_0000,
    S_DIG1   = 11'b000_0100_0000,
    S_DIGS   = 11'b000_1000_0000,
    S_COLON  = 11'b001_0000_0000,
    S_REPORT = 11'b010_0000_0000,
    S_SPARE  = 11'b100_0000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic [ADDR_W-1:0] len_r, len_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [31:0]       acc_r, acc_nxt;
  logic [31:0]       pan_r, pan_nxt;
  logic [31:0]       tilt_r, tilt_nxt;
  logic              neg_r, neg_nxt;
  logic              num_r, num_nxt;
  logic              ok_r, ok_nxt;
  logic [7:0]        c;
  logic [7:0]        dsub;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    acc_r  <= acc_nxt;
    pan_r  <= pan_nxt;
    tilt_r <= tilt_nxt;
    neg_r  <= neg_nxt;
    num_r  <= num_nxt;
    ok_r   <= ok_nxt;
  end

  // past the end of the line the parser sees a zero byte
  assign c          = (pos_r < len_r) ? mem_rdata : 8'd0;
  assign dsub       = c - CH_ZERO;
  assign unit_digit = dsub[3:0];
  assign unit_acc   = acc_r;
  assign mem_waddr  = len_r;
  assign mem_wdata  = byte_r;
  assign mem_raddr  = pos_nxt;

  always_comb begin
    state_nxt = state_r;
    byte_nxt  = byte_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    acc_nxt   = acc_r;
    pan_nxt   = pan_r;
    tilt_nxt  = tilt_r;
    neg_nxt   = neg_r;
    num_nxt   = num_r;
    ok_nxt    = ok_r;
    in_ready  = 1'b0;
    push      = 1'b0;
    res       = '0;
    mem_we    = 1'b0;
    unit_op   = OP_PASS;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        pos_nxt  = '0;
        if (in_valid) begin
          byte_nxt  = in_rx_byte;
          state_nxt = S_ECHO;
        end
      end

      S_ECHO: begin
        if (out_free) begin
          push        = 1'b1;
          res.kind    = KIND_TX;
          res.tx_byte = byte_r;
          priority if ((byte_r == CH_LF) || (byte_r == CH_CR)) begin
            if (len_r != '0) begin
              pos_nxt   = '0;
              acc_nxt   = '0;
              neg_nxt   = 1'b0;
              num_nxt   = 1'b0;
              state_nxt = S_SKIP;
            end else begin
              res.last  = 1'b1;
              state_nxt = S_IDLE;
            end
          end else if ((byte_r == CH_BS) || (byte_r == CH_DEL)) begin
            if (len_r != '0) begin
              len_nxt   = len_r - 1'b1;
              state_nxt = S_SPACE;
            end else begin
              res.last  = 1'b1;
              state_nxt = S_IDLE;
            end
          end else if (len_r < LEN_MAX) begin
            mem_we    = 1'b1;
            len_nxt   = len_r + 1'b1;
            res.last  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            // drop the byte and clear the line
            len_nxt   = '0;
            state_nxt = S_OVF;
          end
        end
      end

      S_SPACE: begin
        if (out_free) begin
          push        = 1'b1;
          res.kind    = KIND_TX;
          res.tx_byte = CH_SPACE;
          state_nxt   = S_BKSP;
        end
      end

      S_BKSP: begin
        if (out_free) begin
          push        = 1'b1;
          res.kind    = KIND_TX;
          res.tx_byte = CH_BS;
          res.last    = 1'b1;
          state_nxt   = S_IDLE;
        end
      end

      S_OVF: begin
        if (out_free) begin
          push           = 1'b1;
          res.kind       = KIND_ERR;
          res.error_code = ERR_OVERFLOW;
          res.last       = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_SKIP: begin
        priority if (is_space(c)) begin
          pos_nxt = pos_r + 1'b1;
        end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
          neg_nxt   = (c == CH_MINUS);
          pos_nxt   = pos_r + 1'b1;
          state_nxt = S_DIG1;
        end else begin
          state_nxt = S_DIG1;
        end
      end

      S_DIG1: begin
        if (is_digit(c)) begin
          unit_op   = OP_MAC;
          acc_nxt   = unit_res;
          pos_nxt   = pos_r + 1'b1;
          state_nxt = S_DIGS;
        end else begin
          ok_nxt    = 1'b0;
          state_nxt = S_REPORT;
        end
      end

      S_DIGS: begin
        if (is_digit(c)) begin
          unit_op = OP_MAC;
          acc_nxt = unit_res;
          pos_nxt = pos_r + 1'b1;
        end else begin
          unit_op = neg_r ? OP_NEG : OP_PASS;
          if (!num_r) begin
            pan_nxt   = unit_res;
            state_nxt = S_COLON;
          end else begin
            tilt_nxt  = unit_res;
            ok_nxt    = 1'b1;
            state_nxt = S_REPORT;
          end
        end
      end

      S_COLON: begin
        if (c == CH_COLON) begin
          pos_nxt   = pos_r + 1'b1;
          num_nxt   = 1'b1;
          acc_nxt   = '0;
          neg_nxt   = 1'b0;
          state_nxt = S_SKIP;
        end else begin
          ok_nxt    = 1'b0;
          state_nxt = S_REPORT;
        end
      end

      S_REPORT: begin
        if (out_free) begin
          push     = 1'b1;
          res.last = 1'b1;
          if (ok_r) begin
            res.kind = KIND_MOVE;
            res.pan  = pan_r;
            res.tilt = tilt_r;
          end else begin
            res.kind       = KIND_ERR;
            res.error_code = ERR_FORMAT;
          end
          len_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/scl_checker.sv]
// ----------------------------------------------------------------------------
// scl_checker
// Port-level checks of the serial command line parser, bound to the top level.
// ----------------------------------------------------------------------------
module scl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_tx_byte,
  input logic [31:0] out_pan,
  input logic [31:0] out_tilt,
  input logic        out_error_code,
  input logic        out_last
);
  import scl_pkg::*;

  // a held request stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_tx_byte)
      && $stable(out_pan) && $stable(out_tilt) && $stable(out_last))
    else $error("output request changed while stalled");

  // a new byte is never taken in the cycle after one was taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken back to back");

  // the block only takes a byte once all requests of the previous one are out
  a_ready_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(out_valid && !out_last))
    else $error("input ready while earlier byte still has requests");

  // move and error requests are the final one of their byte, with a zero transmit byte
  a_report_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_kind == KIND_MOVE) || (out_kind == KIND_ERR))
      |-> out_last && (out_tx_byte == 8'd0))
    else $error("report request not last or carries a byte");

  a_move_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_TX) |-> (out_pan == 32'd0) && (out_tilt == 32'd0)
      && (out_error_code == 1'b0))
    else $error("transmit request carries command fields");

endmodule

bind serial_command_line_parser_unit scl_checker u_scl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_kind       (out_ch.kind),
  .out_tx_byte    (out_ch.tx_byte),
  .out_pan        (out_ch.pan),
  .out_tilt       (out_ch.tilt),
  .out_error_code (out_ch.error_code),
  .out_last       (out_ch.last)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the serial command line parser: streams received
// bytes (commands, edits, noise and full lines) with random bursts and output
// stalls, predicts echoes, moves and errors, and checks every reply in order.
// ----------------------------------------------------------------------------
module tb_top;
  import scl_pkg::*;

  localparam int LINE_CAP   = SCL_LINE_DEPTH;
  localparam int RX_TARGET  = 370;
  localparam int TAIL_WAIT  = LINE_CAP + 16;

  typedef struct {
    logic [7:0] data;
    bit         drain_first;
  } rx_req_t;

  typedef enum int {SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_BLOCKED} sink_mode_t;

  logic clk;
  logic rst_n;

  scl_in_if  in_bus();
  scl_out_if out_bus();

  serial_command_line_parser_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  rx_req_t     rx_queue[$];
  rx_req_t     next_req;
  scl_result_t replies_due[$];
  bit          drain_next;

  // line editor mirror
  logic [7:0] line_chars[LINE_CAP];
  int         line_len = 0;

  int burst_left = 1;
  int gap_left = 0;
  int stall_tick = 0;
  sink_mode_t sink_mode = SINK_OPEN;

  int fail_count = 0;
  int bytes_sent = 0;
  int replies_seen = 0;
  int moves_seen = 0;
  int format_errs = 0;
  int overflow_errs = 0;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] char_at(int p);
    return (p < line_len) ? line_chars[p] : 8'h00;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_numeral(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic bit scan_number(inout int p, output logic [31:0] v);
    logic [31:0] acc;
    bit neg;
    acc = '0;
    neg = 1'b0;
    v = '0;
    while (is_blank(char_at(p))) p++;
    if (char_at(p) == CH_PLUS || char_at(p) == CH_MINUS) begin
      neg = (char_at(p) == CH_MINUS);
      p++;
    end
    if (!is_numeral(char_at(p))) return 1'b0;
    while (is_numeral(char_at(p))) begin
      acc = acc * 32'd10 + 32'(char_at(p) - CH_ZERO);
      p++;
    end
    v = neg ? (32'd0 - acc) : acc;
    return 1'b1;
  endfunction

  function automatic scl_result_t mk_reply(logic [1:0] kind, logic [7:0] tx,
                                           logic [31:0] pan, logic [31:0] tilt,
                                           logic err);
    scl_result_t r;
    r.kind = kind;
    r.tx_byte = tx;
    r.pan = pan;
    r.tilt = tilt;
    r.error_code = err;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic void predict_replies(logic [7:0] c);
    scl_result_t r[$];
    int p;
    logic [31:0] pan_v, tilt_v;
    bit ok;
    r.push_back(mk_reply(KIND_TX, c, '0, '0, 1'b0));
    if (c == CH_CR || c == CH_LF) begin
      if (line_len > 0) begin
        p = 0;
        tilt_v = '0;
        ok = scan_number(p, pan_v);
        if (ok) begin
          ok = (char_at(p) == CH_COLON);
          p++;
        end
        if (ok) ok = scan_number(p, tilt_v);
        if (ok) r.push_back(mk_reply(KIND_MOVE, 8'h00, pan_v, tilt_v, 1'b0));
        else r.push_back(mk_reply(KIND_ERR, 8'h00, '0, '0, ERR_FORMAT));
      end
      line_len = 0;
    end else if (c == CH_BS || c == CH_DEL) begin
      if (line_len > 0) begin
        line_len--;
        r.push_back(mk_reply(KIND_TX, CH_SPACE, '0, '0, 1'b0));
        r.push_back(mk_reply(KIND_TX, CH_BS, '0, '0, 1'b0));
      end
    end else if (line_len < LINE_CAP - 1) begin
      line_chars[line_len] = c;
      line_len++;
    end else begin
      // drop the byte and clear the line
      line_len = 0;
      r.push_back(mk_reply(KIND_ERR, 8'h00, '0, '0, ERR_OVERFLOW));
    end
    r[r.size() - 1].last = 1'b1;
    foreach (r[i]) replies_due.push_back(r[i]);
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        predict_replies(in_bus.rx_byte);
        bytes_sent++;
      end
      // hold a request that is still waiting
      if (!(in_bus.valid && !in_bus.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_bus.valid <= 1'b0;
        end else if (rx_queue.size() == 0 ||
                     (rx_queue[0].drain_first && replies_due.size() != 0)) begin
          in_bus.valid <= 1'b0;
        end else begin
          next_req = rx_queue.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.rx_byte <= next_req.data;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  function automatic void check_reply();
    scl_result_t want;
    replies_seen++;
    if (replies_due.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected reply, expected none, actual kind %0d tx %0h", $time,
               out_bus.kind, out_bus.tx_byte);
      return;
    end
    want = replies_due.pop_front();
    compare_field("kind", 32'(want.kind), 32'(out_bus.kind));
    compare_field("tx_byte", 32'(want.tx_byte), 32'(out_bus.tx_byte));
    compare_field("pan", want.pan, out_bus.pan);
    compare_field("tilt", want.tilt, out_bus.tilt);
    compare_field("error_code", 32'(want.error_code), 32'(out_bus.error_code));
    compare_field("last", 32'(want.last), 32'(out_bus.last));
    if (want.kind == KIND_MOVE) moves_seen++;
    if (want.kind == KIND_ERR && want.error_code == ERR_FORMAT) format_errs++;
    if (want.kind == KIND_ERR && want.error_code == ERR_OVERFLOW) overflow_errs++;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) check_reply();
      stall_tick++;
      if (stall_tick % 48 == 0) sink_mode = sink_mode_t'($urandom_range(0, 3));
      case (sink_mode)
        SINK_OPEN:  out_bus.ready <= 1'b1;
        SINK_LIGHT: out_bus.ready <= ($urandom_range(0, 3) != 0);
        SINK_HEAVY: out_bus.ready <= ($urandom_range(0, 2) == 0);
        default:    out_bus.ready <= ((stall_tick % 16) >= 11);
      endcase
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic push_rx(logic [7:0] b);
    rx_req_t req;
    req.data = b;
    req.drain_first = drain_next;
    drain_next = 1'b0;
    rx_queue.push_back(req);
  endtask

  // any byte that is stored rather than acted on
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_BS || b == CH_DEL || b == CH_CR || b == CH_LF);
    return b;
  endfunction

  function automatic logic [7:0] line_end();
    return ($urandom_range(0, 1) == 0) ? CH_CR : CH_LF;
  endfunction

  task automatic add_number(ref logic [7:0] txt[$]);
    int n;
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0: txt.push_back(CH_SPACE);
        1: txt.push_back(CH_TAB);
        2: txt.push_back(8'd11);
        default: txt.push_back(8'd12);
      endcase
    end
    case ($urandom_range(0, 2))
      0: txt.push_back(CH_PLUS);
      1: txt.push_back(CH_MINUS);
      default: ;
    endcase
    // some long numbers to wrap past 32 bits
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
    repeat (n) txt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic add_command(bit broken);
    logic [7:0] txt[$];
    int k;
    add_number(txt);
    txt.push_back(CH_COLON);
    add_number(txt);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) txt.push_back(plain_byte());
    if (broken) begin
      k = $urandom_range(0, txt.size() - 1);
      if ($urandom_range(0, 1) == 0) txt[k] = plain_byte();
      else txt.delete(k);
    end
    foreach (txt[i]) begin
      // type a stray character and erase it
      if ($urandom_range(0, 11) == 0) begin
        push_rx(plain_byte());
        push_rx(($urandom_range(0, 1) == 0) ? CH_BS : CH_DEL);
      end
      push_rx(txt[i]);
    end
    push_rx(line_end());
    if ($urandom_range(0, 5) == 0) push_rx(line_end());
  endtask

  task automatic add_noise();
    repeat ($urandom_range(1, 10)) push_rx(8'($urandom_range(0, 255)));
    push_rx(line_end());
  endtask

  task automatic add_full_line();
    logic [7:0] txt[$];
    add_number(txt);
    txt.push_back(CH_COLON);
    add_number(txt);
    while (txt.size() < LINE_CAP - 1) txt.push_back(plain_byte());
    foreach (txt[i]) push_rx(txt[i]);
    case ($urandom_range(0, 2))
      0: push_rx(plain_byte());
      1: push_rx(line_end());
      default: begin
        push_rx(CH_DEL);
        push_rx(plain_byte());
        push_rx(plain_byte());
      end
    endcase
  endtask

  initial begin
    bit full_done;
    full_done = 1'b0;
    drain_next = 1'b0;
    rst_n = 1'b0;

    // line ends and erases on an empty line
    push_rx(CH_CR);
    push_rx(CH_BS);
    push_rx(CH_DEL);
    push_rx(CH_LF);
    // plain and signed commands
    push_rx(CH_ZERO + 8'd1);
    push_rx(CH_COLON);
    push_rx(CH_ZERO + 8'd2);
    push_rx(CH_CR);
    push_rx(CH_MINUS);
    push_rx(CH_ZERO + 8'd7);
    push_rx(CH_COLON);
    push_rx(CH_PLUS);
    push_rx(CH_ZERO + 8'd9);
    push_rx(CH_LF);
    // erase back to empty, then once more
    push_rx(8'h78);
    push_rx(CH_DEL);
    push_rx(CH_BS);
    // a zero byte ends parsing; a high byte is not a digit
    push_rx(8'h00);
    push_rx(CH_LF);
    push_rx(8'hFF);
    push_rx(CH_CR);

    drain_next = 1'b1;
    while (rx_queue.size() < RX_TARGET) begin
      if (!full_done && rx_queue.size() > RX_TARGET / 2) begin
        drain_next = 1'b1;
        add_full_line();
        full_done = 1'b1;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: add_command(1'b0);
          6, 7: add_command(1'b1);
          8: add_noise();
          default: if ($urandom_range(0, 3) == 0) add_full_line(); else add_noise();
        endcase
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (rx_queue.size() != 0 || in_bus.valid) @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("Sent %0d bytes, checked %0d replies: %0d moves, %0d format errors,",
             bytes_sent, replies_seen, moves_seen, format_errs);
    $display("%0d line overflows, under random bursts and output stalls.", overflow_errs);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[serial_command_line_parser_unit.f]
rtl/scl_pkg.sv
rtl/scl_ifs.sv
rtl/scl_line_mem.sv
rtl/scl_acc_unit.sv
rtl/scl_ctrl.sv
rtl/serial_command_line_parser_unit.sv
rtl/scl_checker.sv
tb/tb_top.sv
